/* rtl/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Sizes, operation and register codes, sequencer states and the structs that
// pass between the sequencer, the probe unit and the slot memories.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_BITS  = 12;
  localparam int COUNT_BITS  = 9;
  localparam int NSLOTS      = 1 << TABLE_BITS;
  localparam int KEY_W       = 32;
  localparam int KIND_W      = 2;
  localparam int IN_COUNT_W  = 9;
  localparam int OUT_COUNT_W = 9;
  localparam int IDXB_W      = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int ENTRY_W     = KEY_W + COUNT_BITS;
  localparam logic [IDXB_W-1:0] IDXB_RESET = IDXB_W'(12);

  typedef logic [TABLE_BITS-1:0] slot_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam slot_t SLOT_LAST = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_ENABLED = 1'b0,
    CFG_INDEX_BITS    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PROBE,
    ST_RESULT
  } state_t;

  // Context of the probe in flight.
  typedef struct packed {
    kind_t            op;
    logic [KEY_W-1:0] key;
    slot_t            pos;
    slot_t            n;
  } probe_ctx_t;

  // Verdict of the probe unit on the slot just read.
  typedef struct packed {
    logic  done;
    logic  found;
    logic  full;
    logic  wr;
    slot_t next_pos;
    cnt_t  hit_count;
  } probe_res_t;

  // Slot memory controls.
  typedef struct packed {
    slot_t              raddr;
    slot_t              waddr;
    logic               used_we;
    logic               used_wdata;
    logic               entry_we;
    logic [ENTRY_W-1:0] entry_wdata;
  } ram_ctl_t;

  // Mask of the slots in use, with the index width clamped to 1..TABLE_BITS.
  function automatic slot_t live_mask(input logic [IDXB_W-1:0] b);
    int                  cb;
    logic [TABLE_BITS:0] w;
    cb = int'(b);
    if (cb < 1) cb = 1;
    if (cb > TABLE_BITS) cb = TABLE_BITS;
    w = ((TABLE_BITS + 1)'(1) << cb) - (TABLE_BITS + 1)'(1);
    return w[TABLE_BITS-1:0];
  endfunction

  // Saturate an incoming count to the stored count width.
  function automatic cnt_t sat_count(input logic [IN_COUNT_W-1:0] c);
    logic [32:0] wide;
    logic [32:0] lim;
    wide = 33'(c);
    lim  = (33'(1) << COUNT_BITS) - 33'(1);
    return (wide > lim) ? lim[COUNT_BITS-1:0] : wide[COUNT_BITS-1:0];
  endfunction

endpackage

/* rtl/lpht_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table channel interfaces
// Valid/ready channels for operation beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  import lpht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [KEY_W-1:0]      key;
  logic [IN_COUNT_W-1:0] count;
  modport source (output valid, kind, key, count, input ready);
  modport sink   (input valid, kind, key, count, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_COUNT_W-1:0] count_out;
  logic                   found;
  logic                   full_res;
  modport source (output valid, count_out, found, full_res, input ready);
  modport sink   (input valid, count_out, found, full_res, output ready);
endinterface

interface lpht_cfg_if;
  import lpht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key to count table with linear probing over a shared read
// address of the slot memories, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: each beat on in_ch carries one operation (clear, insert or lookup)
// with a 32-bit key and a count. Every beat gives exactly one result beat on
// out_ch: the count and found flag of a lookup, or the full flag of an
// insert that saw no empty slot in a whole pass over the slots in use.
// Registers are written on cfg_ch, which is always ready; write them only
// while the block is idle.
// Timing: the slot memories are read once per cycle. The result beat of a
// lookup or insert is offered at the same edge at which in_ch becomes
// ready again. A disabled lookup or an unknown operation goes straight to
// its result without probing a slot. Clear sweeps the used flags at one
// slot a cycle.
// Reset: the same sweep runs after reset over every slot, during
// which in_ch is not ready. If the receiver stalls, the result waits in the
// output register and the block still takes and works on the next beat; it
// only holds that beat's result back until the output register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input logic        clk,
  input logic        rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch,
  lpht_cfg_if.sink   cfg_ch
);
  import lpht_pkg::*;

  // Configuration registers.
  logic              enabled_r, enabled_nxt;
  logic [IDXB_W-1:0] idx_bits_r, idx_bits_nxt;
  slot_t             mask;

  probe_ctx_t       ctx;
  probe_res_t       pr;
  ram_ctl_t         ram;
  logic             rd_used;
  logic [ENTRY_W-1:0] rd_entry;

  assign cfg_ch.ready = 1'b1;

  // A register write lands on every beat; index codes outside the list do
  // nothing.
  always_comb begin
    enabled_nxt  = enabled_r;
    idx_bits_nxt = idx_bits_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_TABLE_ENABLED: enabled_nxt  = cfg_ch.wdata[0];
        CFG_INDEX_BITS:    idx_bits_nxt = cfg_ch.wdata[IDXB_W-1:0];
        default: begin
          enabled_nxt = enabled_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      idx_bits_r <= IDXB_RESET;
    end else begin
      enabled_r  <= enabled_nxt;
      idx_bits_r <= idx_bits_nxt;
    end
  end

  // The index width is clamped here, so the home slot and the wrap both use
  // only the slots in use. Entries placed under an older mask stay put.
  assign mask = live_mask(idx_bits_r);

  lpht_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .enabled (enabled_r),
    .mask    (mask),
    .pr      (pr),
    .ctx     (ctx),
    .ram     (ram)
  );

  // The used flags live in their own memory so that a clear touches only
  // them; key and count of a slot are used only once it is marked used.
  lpht_ram #(
    .WIDTH (1),
    .DEPTH (NSLOTS)
  ) u_used_ram (
    .clk   (clk),
    .we    (ram.used_we),
    .waddr (ram.waddr),
    .wdata (ram.used_wdata),
    .raddr (ram.raddr),
    .rdata (rd_used)
  );

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NSLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram.entry_we),
    .waddr (ram.waddr),
    .wdata (ram.entry_wdata),
    .raddr (ram.raddr),
    .rdata (rd_entry)
  );

  lpht_probe u_probe (
    .ctx      (ctx),
    .mask     (mask),
    .rd_used  (rd_used),
    .rd_key   (rd_entry[ENTRY_W-1:COUNT_BITS]),
    .rd_count (rd_entry[COUNT_BITS-1:0]),
    .res      (pr)
  );

endmodule

/* rtl/lpht_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lpht_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table probe unit
// Judges the slot just read: key compare, empty test, pass end and the
// wrapped step to the next slot.
// ----------------------------------------------------------------------------
module lpht_probe (
  input  lpht_pkg::probe_ctx_t       ctx,
  input  lpht_pkg::slot_t            mask,
  input  logic                       rd_used,
  input  logic [lpht_pkg::KEY_W-1:0] rd_key,
  input  lpht_pkg::cnt_t             rd_count,
  output lpht_pkg::probe_res_t       res
);
  import lpht_pkg::*;

  logic last;

  assign last = (ctx.n == mask);

  always_comb begin
    res           = '0;
    res.next_pos  = slot_t'(ctx.pos + 1'b1) & mask;
    res.hit_count = rd_count;
    case (ctx.op)
      KIND_INSERT: begin
        if (!rd_used) begin
          res.done = 1'b1;
          res.wr   = 1'b1;
        end else if (last) begin
          // A whole pass without an empty slot: the table is full.
          res.done = 1'b1;
          res.full = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (!rd_used) begin
          res.done = 1'b1;
        end else if (rd_key == ctx.key) begin
          res.done  = 1'b1;
          res.found = 1'b1;
        end else if (last) begin
          res.done = 1'b1;
        end
      end
      default: begin
        res.done = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/lpht_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table sequencer
// Takes operation beats, runs the clearing sweep and the slot probe loop,
// and holds the result in a register ahead of the result channel.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  lpht_in_if.sink              in_ch,
  lpht_out_if.source           out_ch,
  input  logic                 enabled,
  input  lpht_pkg::slot_t      mask,
  input  lpht_pkg::probe_res_t pr,
  output lpht_pkg::probe_ctx_t ctx,
  output lpht_pkg::ram_ctl_t   ram
);
  import lpht_pkg::*;

  state_t                 state_r, state_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  cnt_t                   cnt_r, cnt_nxt;
  slot_t                  pos_r, pos_nxt;
  slot_t                  n_r, n_nxt;
  slot_t                  clr_r, clr_nxt;
  logic [OUT_COUNT_W-1:0] res_count_r, res_count_nxt;
  logic                   res_found_r, res_found_nxt;
  logic                   res_full_r, res_full_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_found_r, out_found_nxt;
  logic                   out_full_r, out_full_nxt;

  logic  accept;
  logic  out_free;
  logic  clr_last;
  slot_t home;
  kind_t in_kind;

  assign in_kind  = kind_t'(in_ch.kind);
  assign home     = in_ch.key[TABLE_BITS-1:0] & mask;
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = (clr_r == SLOT_LAST);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_CLEAR:  state_nxt = ST_CLEAR;
            KIND_INSERT: state_nxt = ST_PROBE;
            KIND_LOOKUP: state_nxt = enabled ? ST_PROBE : ST_RESULT;
            default:     state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_RESULT;
      end
      ST_PROBE: begin
        if (pr.done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Outputs of the sequencer: handshake and memory controls.
  always_comb begin
    in_ch.ready     = (state_r == ST_IDLE);
    ram             = '0;
    ram.raddr       = (state_r == ST_PROBE) ? pr.next_pos : home;
    ram.entry_wdata = {key_r, cnt_r};
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram.waddr      = clr_r;
        ram.used_we    = 1'b1;
        ram.used_wdata = 1'b0;
      end
      ST_PROBE: begin
        ram.waddr      = pos_r;
        ram.used_we    = pr.wr;
        ram.used_wdata = 1'b1;
        ram.entry_we   = pr.wr;
      end
      default: begin
        ram.waddr = pos_r;
      end
    endcase
  end

  assign ctx.op  = kind_r;
  assign ctx.key = key_r;
  assign ctx.pos = pos_r;
  assign ctx.n   = n_r;

  // Datapath registers.
  always_comb begin
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    res_count_nxt = res_count_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;

    if (accept) begin
      kind_nxt      = in_kind;
      key_nxt       = in_ch.key;
      cnt_nxt       = sat_count(in_ch.count);
      pos_nxt       = home;
      n_nxt         = '0;
      clr_nxt       = '0;
      res_count_nxt = '0;
      res_found_nxt = 1'b0;
      res_full_nxt  = 1'b0;
    end

    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      clr_nxt = slot_t'(clr_r + 1'b1);
    end

    if (state_r == ST_PROBE) begin
      if (pr.done) begin
        res_count_nxt = pr.found ? OUT_COUNT_W'(pr.hit_count) : '0;
        res_found_nxt = pr.found;
        res_full_nxt  = pr.full;
      end else begin
        pos_nxt = pr.next_pos;
        n_nxt   = slot_t'(n_r + 1'b1);
      end
    end

    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (state_r == ST_RESULT && out_free) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = res_count_r;
      out_found_nxt = res_found_r;
      out_full_nxt  = res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    cnt_r       <= cnt_nxt;
    pos_r       <= pos_nxt;
    n_r         <= n_nxt;
    res_count_r <= res_count_nxt;
    res_found_r <= res_found_nxt;
    res_full_r  <= res_full_nxt;
    out_count_r <= out_count_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.count_out = out_count_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.full_res  = out_full_r;

endmodule

/* rtl/lpht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [lpht_pkg::OUT_COUNT_W-1:0] count_out,
  input logic                             found,
  input logic                             full_res
);
  import lpht_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(count_out) && $stable(found) && $stable(full_res))
    else $error("result payload changed while stalled");

  // One operation at a time: the block is busy right after taking a beat.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operation beat taken while busy");

  // Only a hit carries a count, and a hit never reports a full table.
  a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && full_res) && (found || count_out == '0))
    else $error("inconsistent result beat");

  // Reset starts the clearing sweep: nothing is taken or offered.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channels active straight after reset");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .count_out (out_ch.count_out),
  .found     (out_ch.found),
  .full_res  (out_ch.full_res)
);
